// ===== rtl/euclidean_distance_isqrt_defines.svh =====
// Assertion macros shared by the Euclidean distance RTL.
`ifndef EUCLIDEAN_DISTANCE_ISQRT_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_ISQRT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/edi_pkg.sv =====
// Shared constants, types and control structures for the Euclidean distance block.
`timescale 1ns / 1ps

package edi_pkg;

  localparam int COORD_BITS = 16;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int CNT_BITS   = $clog2(COORD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_DONE
  } edi_state_t;

  typedef struct packed {
    logic sq_load;
    logic sq_step;
    logic rt_load;
    logic rt_step;
  } edi_ctrl_t;

endpackage

// ===== rtl/edi_sqsum.sv =====
// Bit-serial sum of squares of two signed offsets, one multiplier bit per cycle while sq_step is high.
`timescale 1ns / 1ps

module edi_sqsum (
  input  logic                                clk,
  input  edi_pkg::edi_ctrl_t                  ctrl,
  input  logic signed [edi_pkg::COORD_BITS-1:0] offset_x,
  input  logic signed [edi_pkg::COORD_BITS-1:0] offset_y,
  output logic        [edi_pkg::SQ_BITS-1:0]    sum_sq
);

  logic [edi_pkg::COORD_BITS-1:0] ax_r, ax_nxt;
  logic [edi_pkg::COORD_BITS-1:0] ay_r, ay_nxt;
  logic [edi_pkg::COORD_BITS-1:0] mx_r, mx_nxt;
  logic [edi_pkg::COORD_BITS-1:0] my_r, my_nxt;
  logic [edi_pkg::COORD_BITS:0]   hi_r, hi_nxt;
  logic [edi_pkg::COORD_BITS-1:0] lo_r, lo_nxt;
  logic [edi_pkg::COORD_BITS-1:0] mag_x;
  logic [edi_pkg::COORD_BITS-1:0] mag_y;
  logic [edi_pkg::COORD_BITS:0]   term_x;
  logic [edi_pkg::COORD_BITS:0]   term_y;
  logic [edi_pkg::COORD_BITS+1:0] acc;

  always_comb begin
    mag_x = offset_x[edi_pkg::COORD_BITS-1] ? (~offset_x + 1'b1) : offset_x;
    mag_y = offset_y[edi_pkg::COORD_BITS-1] ? (~offset_y + 1'b1) : offset_y;
    term_x = {1'b0, ax_r} & {(edi_pkg::COORD_BITS+1){mx_r[0]}};
    term_y = {1'b0, ay_r} & {(edi_pkg::COORD_BITS+1){my_r[0]}};
    acc = {1'b0, hi_r} + {1'b0, term_x} + {1'b0, term_y};
    ax_nxt = ax_r;
    ay_nxt = ay_r;
    mx_nxt = mx_r;
    my_nxt = my_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (ctrl.sq_load) begin
      ax_nxt = mag_x;
      ay_nxt = mag_y;
      mx_nxt = mag_x;
      my_nxt = mag_y;
      hi_nxt = '0;
      lo_nxt = '0;
    end else if (ctrl.sq_step) begin
      mx_nxt = {1'b0, mx_r[edi_pkg::COORD_BITS-1:1]};
      my_nxt = {1'b0, my_r[edi_pkg::COORD_BITS-1:1]};
      hi_nxt = acc[edi_pkg::COORD_BITS+1:1];
      lo_nxt = {acc[0], lo_r[edi_pkg::COORD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    mx_r <= mx_nxt;
    my_r <= my_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign sum_sq = {hi_r[edi_pkg::COORD_BITS-1:0], lo_r};

endmodule

// ===== rtl/edi_isqrt.sv =====
// Restoring digit-by-digit integer square root, one root bit per cycle while rt_step is high.
`timescale 1ns / 1ps

module edi_isqrt (
  input  logic                              clk,
  input  edi_pkg::edi_ctrl_t                ctrl,
  input  logic [edi_pkg::SQ_BITS-1:0]       sum_sq,
  output logic [edi_pkg::COORD_BITS-1:0]    root
);

  logic [edi_pkg::SQ_BITS-1:0]    nsh_r, nsh_nxt;
  logic [edi_pkg::COORD_BITS:0]   rem_r, rem_nxt;
  logic [edi_pkg::COORD_BITS-1:0] root_r, root_nxt;
  logic [edi_pkg::COORD_BITS+2:0] rem_ext;
  logic [edi_pkg::COORD_BITS+2:0] trial;
  logic [edi_pkg::COORD_BITS+2:0] diff;
  logic                           fits;

  always_comb begin
    rem_ext = {rem_r, nsh_r[edi_pkg::SQ_BITS-1:edi_pkg::SQ_BITS-2]};
    trial   = {1'b0, root_r, 2'b01};
    diff    = rem_ext - trial;
    fits    = (rem_ext >= trial);
    nsh_nxt  = nsh_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (ctrl.rt_load) begin
      nsh_nxt  = sum_sq;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (ctrl.rt_step) begin
      nsh_nxt  = {nsh_r[edi_pkg::SQ_BITS-3:0], 2'b00};
      rem_nxt  = fits ? diff[edi_pkg::COORD_BITS:0] : rem_ext[edi_pkg::COORD_BITS:0];
      root_nxt = {root_r[edi_pkg::COORD_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    nsh_r  <= nsh_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;

endmodule

// ===== rtl/euclidean_distance_isqrt.sv =====
// Top level of the Euclidean distance block: sequencer, datapath units and result register.
// Each request passes through ST_SQUARE (bit-serial squarer, one multiplier bit a cycle), ST_LOAD,
// ST_ROOT (bit-serial root, one root bit a cycle) and ST_DONE; a new request is accepted only
// once the sequencer has finished the previous one and returned to idle.
// A finished result waits in the output register while the next request is accepted.
// Synchronous active-low reset returns the sequencer to idle and clears out_valid.
`timescale 1ns / 1ps
`include "euclidean_distance_isqrt_defines.svh"

module euclidean_distance_isqrt (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [edi_pkg::COORD_BITS-1:0] in_offset_x,
  input  logic signed [edi_pkg::COORD_BITS-1:0] in_offset_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [edi_pkg::COORD_BITS-1:0] out_distance
);

  edi_pkg::edi_state_t            state_r, state_nxt;
  logic [edi_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [edi_pkg::COORD_BITS-1:0] dist_r, dist_nxt;
  edi_pkg::edi_ctrl_t             ctrl;
  logic                           out_load;
  logic                           cnt_load;
  logic [edi_pkg::SQ_BITS-1:0]    sum_sq;
  logic [edi_pkg::COORD_BITS-1:0] root;

  edi_sqsum u_sqsum (
    .clk      (clk),
    .ctrl     (ctrl),
    .offset_x (in_offset_x),
    .offset_y (in_offset_y),
    .sum_sq   (sum_sq)
  );

  edi_isqrt u_isqrt (
    .clk    (clk),
    .ctrl   (ctrl),
    .sum_sq (sum_sq),
    .root   (root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edi_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = edi_pkg::ST_SQUARE;
      end
      edi_pkg::ST_SQUARE: begin
        if (cnt_r == '0) state_nxt = edi_pkg::ST_LOAD;
      end
      edi_pkg::ST_LOAD: begin
        state_nxt = edi_pkg::ST_ROOT;
      end
      edi_pkg::ST_ROOT: begin
        if (cnt_r == '0) state_nxt = edi_pkg::ST_DONE;
      end
      edi_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = edi_pkg::ST_IDLE;
      end
      default: state_nxt = edi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    cnt_load = 1'b0;
    unique case (state_r)
      edi_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.sq_load = in_valid;
        cnt_load     = in_valid;
      end
      edi_pkg::ST_SQUARE: begin
        ctrl.sq_step = 1'b1;
      end
      edi_pkg::ST_LOAD: begin
        ctrl.rt_load = 1'b1;
        cnt_load     = 1'b1;
      end
      edi_pkg::ST_ROOT: begin
        ctrl.rt_step = 1'b1;
      end
      edi_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cnt_load) begin
      cnt_nxt = edi_pkg::CNT_BITS'(edi_pkg::COORD_BITS - 1);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - edi_pkg::CNT_BITS'(1);
    end
    dist_nxt      = out_load ? root : dist_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edi_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;

  `EDI_ASSERT_NEXT(a_accept_starts_square, in_valid && in_ready, state_r == edi_pkg::ST_SQUARE, "Accepted request did not start squaring.")
  `EDI_ASSERT_NEXT(a_square_to_load, state_r == edi_pkg::ST_SQUARE && cnt_r == '0, state_r == edi_pkg::ST_LOAD, "Squaring did not end after the last bit.")
  `EDI_ASSERT_NEXT(a_root_to_done, state_r == edi_pkg::ST_ROOT && cnt_r == '0, state_r == edi_pkg::ST_DONE, "Root did not end after the last bit.")
  `EDI_ASSERT_NEXT(a_result_not_overwritten, state_r == edi_pkg::ST_DONE && out_valid_r && !out_ready, state_r == edi_pkg::ST_DONE && out_valid_r, "Finished result left while the output was still occupied.")

endmodule

// ===== bench/euclidean_distance_isqrt_tb.sv =====
// Self-checking testbench for the Euclidean distance block, with directed and random requests.
`timescale 1ns / 1ps

module euclidean_distance_isqrt_tb;

  localparam int CW          = edi_pkg::COORD_BITS;
  localparam int RANDOM_REQS = 1230;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 2 * edi_pkg::COORD_BITS + 20;

  typedef struct packed {
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 fixed;
    logic [CW-1:0]        exp_dist;
  } offset_row_t;

  localparam int ROWS = 21;

  localparam offset_row_t DIRECTED [ROWS] = '{
    '{16'sd0,      16'sd0,      1'b1, 16'd0},
    '{16'sd1,      16'sd0,      1'b1, 16'd1},
    '{16'sd0,      16'shFFFF,   1'b1, 16'd1},
    '{16'sd3,      16'sd4,      1'b1, 16'd5},
    '{16'shFFFD,   16'shFFFC,   1'b1, 16'd5},
    '{16'sd1,      16'sd1,      1'b1, 16'd1},
    '{16'sd32767,  16'sd0,      1'b1, 16'd32767},
    '{16'sh8000,   16'sd0,      1'b1, 16'd32768},
    '{16'sd0,      16'sh8000,   1'b1, 16'd32768},
    '{16'sd32767,  16'sd32767,  1'b1, 16'd46339},
    '{16'sh8000,   16'sh8000,   1'b1, 16'd46340},
    '{16'sh8000,   16'sd32767,  1'b0, 16'd0},
    '{16'sd32767,  16'sh8000,   1'b0, 16'd0},
    '{16'sd2,      16'sd2,      1'b0, 16'd0},
    '{16'shFFFF,   16'shFFFF,   1'b0, 16'd0},
    '{16'sd255,    16'shFF00,   1'b0, 16'd0},
    '{16'sd12345,  16'shE57B,   1'b0, 16'd0},
    '{16'shFFFF,   16'sd32767,  1'b0, 16'd0},
    '{16'sh5555,   16'shAAAA,   1'b0, 16'd0},
    '{16'sh7FFE,   16'sh0001,   1'b0, 16'd0},
    '{16'sd100,    16'sd100,    1'b0, 16'd0}
  };

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_offset_x  = '0;
  logic signed [CW-1:0] in_offset_y  = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [CW-1:0]        out_distance;

  logic [CW-1:0] pending_dist[$];
  int            mismatches  = 0;
  int            strays      = 0;
  int            sent_count  = 0;
  bit            send_quiet  = 1'b0;
  bit            recv_quiet  = 1'b0;
  bit            hold_done   = 1'b0;

  euclidean_distance_isqrt u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_offset_x  (in_offset_x),
    .in_offset_y  (in_offset_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CW-1:0] predict_distance(logic signed [CW-1:0] ox,
                                                     logic signed [CW-1:0] oy);
    longint            sx;
    longint            sy;
    longint unsigned   ax;
    longint unsigned   ay;
    longint unsigned   sum_sq;
    longint unsigned   guess;
    longint unsigned   quot;
    sx = longint'(ox);
    sy = longint'(oy);
    ax = (sx < 0) ? longint'(-sx) : sx;
    ay = (sy < 0) ? longint'(-sy) : sy;
    sum_sq = ax * ax + ay * ay;
    guess = sum_sq;
    quot = 1;
    while (guess > quot) begin
      guess = (guess + quot) >> 1;
      if (guess == 0) return '0;
      quot = sum_sq / guess;
    end
    return guess[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] random_offset();
    logic signed [CW-1:0] mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(CW-1){1'b0}}};
          1:       return {1'b0, {(CW-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2: begin
        mag = CW'($urandom_range(0, 40));
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_request(logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
                              logic fixed, logic [CW-1:0] exp_dist);
    int gap;
    in_offset_x <= dx;
    in_offset_y <= dy;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_dist.push_back(fixed ? exp_dist : predict_distance(dx, dy));
    sent_count++;
    if ($urandom_range(0, 59) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_dist.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10)
          $display("Unexpected result: distance %0d", out_distance);
      end else begin
        if (out_distance !== pending_dist[0]) begin
          mismatches++;
          if (strays + mismatches <= 10)
            $display("Distance mismatch: expected %0d, actual %0d",
                     pending_dist[0], out_distance);
        end
        void'(pending_dist.pop_front());
      end
    end
  end

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 59) == 0) recv_quiet = !recv_quiet;
        stall = recv_quiet ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i])
      send_request(DIRECTED[i].dx, DIRECTED[i].dy, DIRECTED[i].fixed, DIRECTED[i].exp_dist);
    for (int i = 0; i < RANDOM_REQS; i++)
      send_request(random_offset(), random_offset(), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && strays == 0 && pending_dist.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== euclidean_distance_isqrt.f =====
+incdir+rtl
rtl/edi_pkg.sv
rtl/edi_sqsum.sv
rtl/edi_isqrt.sv
rtl/euclidean_distance_isqrt.sv
bench/euclidean_distance_isqrt_tb.sv
